// File: hdl/sft_pkg.sv
package sft_pkg;

   // default sizes
   localparam int TABLE_DEPTH_DEFAULT = 256;
   localparam int LINE_BITS_DEFAULT   = 16;

   // fixed field widths
   localparam int LEVEL_BITS  = 7;
   localparam int CMD_BITS    = 3;
   localparam int STATUS_BITS = 3;
   localparam int LINE_FIELD_BITS  = 16;
   localparam int INDEX_FIELD_BITS = 8;
   localparam int TOTAL_FIELD_BITS = 9;

   localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = 7'd99;

   // command codes
   localparam logic [CMD_BITS-1:0] CMD_FLOOR   = 3'd0;
   localparam logic [CMD_BITS-1:0] CMD_INSERT  = 3'd1;
   localparam logic [CMD_BITS-1:0] CMD_DELETE  = 3'd2;
   localparam logic [CMD_BITS-1:0] CMD_PROMOTE = 3'd3;
   localparam logic [CMD_BITS-1:0] CMD_DEMOTE  = 3'd4;
   localparam logic [CMD_BITS-1:0] CMD_OPEN    = 3'd5;
   localparam logic [CMD_BITS-1:0] CMD_CLOSE   = 3'd6;

   // status codes
   localparam logic [STATUS_BITS-1:0] STATUS_DONE    = 3'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_NOMATCH = 3'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_ALREADY = 3'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_REFUSED = 3'd3;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL    = 3'd4;

   // cell operation codes
   localparam logic [1:0] OP_NONE   = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;
   localparam logic [1:0] OP_MODIFY = 2'd3;

   typedef struct packed {
      logic [LEVEL_BITS-1:0] level;
      logic                  open;
   } attr_type;

   typedef struct packed {
      logic     search;
      logic [1:0] op;
      attr_type attr;
   } ctl_type;

endpackage

// File: hdl/sft_cell.sv
module sft_cell #(
   parameter int KEY_BITS   = 16,
   parameter int CNT_BITS   = 9,
   parameter int CELL_INDEX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sft_pkg::ctl_type      ctl,
   input  logic [KEY_BITS-1:0]   key,
   input  logic [CNT_BITS-1:0]   used_count,
   input  logic                  prev_le_ff,
   input  logic                  next_le_ff,
   input  logic [KEY_BITS-1:0]   prev_line,
   input  sft_pkg::attr_type     prev_attr,
   input  logic [KEY_BITS-1:0]   next_line,
   input  sft_pkg::attr_type     next_attr,
   output logic [KEY_BITS-1:0]   line_ff,
   output sft_pkg::attr_type     attr_ff,
   output logic                  le,
   output logic                  le_ff
);
   import sft_pkg::*;

   logic                occupied;
   logic [KEY_BITS-1:0] line_in;
   attr_type            attr_in;

   // entry held and not above the key
   assign occupied = used_count > CNT_BITS'(CELL_INDEX);
   assign le       = occupied && (line_ff <= key);

   always_ff @(posedge clock) begin
      if (reset) begin
         le_ff <= 1'b0;
      end else if (ctl.search) begin
         le_ff <= le;
      end
   end

   // shift, load or modify from the broadcast operation
   always_comb begin
      line_in = line_ff;
      attr_in = attr_ff;
      unique case (ctl.op)
         OP_NONE: begin
         end
         OP_INSERT: begin
            if (!le_ff) begin
               if (prev_le_ff) begin
                  line_in = key;
                  attr_in = ctl.attr;
               end else begin
                  line_in = prev_line;
                  attr_in = prev_attr;
               end
            end
         end
         OP_DELETE: begin
            if (!next_le_ff) begin
               line_in = next_line;
               attr_in = next_attr;
            end
         end
         OP_MODIFY: begin
            if (le_ff && !next_le_ff) begin
               attr_in = ctl.attr;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      line_ff <= line_in;
      attr_ff <= attr_in;
   end

endmodule

// File: hdl/sorted_fold_table.sv
// sorted fold table: a sorted table of fold entries (line, level, open flag)
// held in a row of compare-and-shift cells, one entry per cell.
// request channel: req_tuser carries the command, req_tdata the line number.
// response channel: one word per request, status in rsp_tuser, the entry
// fields and the entry count in rsp_tdata.
// each command runs through a search state, in which every cell compares its
// line against the key in parallel and the floor entry is selected, and an
// update state, in which the result is formed and the cells shift or update.
// req_tready is high while idle and in the update state when the result is
// emitted, so a new request can be taken as the previous result is emitted;
// rsp_tvalid comes from the response register, loaded as the result is emitted.
// the response sits in an output register; if the receiver stalls, one
// request is still taken and searched, then the block waits in the update
// state until the held word is taken.
// synchronous reset empties the table (count to zero) and clears the
// response; entry contents are not cleared.
module sorted_fold_table #(
   parameter int TABLE_DEPTH = sft_pkg::TABLE_DEPTH_DEFAULT,
   parameter int LINE_BITS   = sft_pkg::LINE_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] line_number
   input  logic [2:0]  req_tuser,   // [2:0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [7:0] entry_index, [23:8] entry_line,
                                    // [30:24] entry_level, [31] entry_open,
                                    // [40:32] entry_total, [47:41] zero
   output logic [2:0]  rsp_tuser    // [2:0] status
);
   import sft_pkg::*;

   localparam int KEY_BITS = (LINE_BITS < LINE_FIELD_BITS) ? LINE_BITS : LINE_FIELD_BITS;
   localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W    = $clog2(TABLE_DEPTH);
   localparam int ATTR_W   = LEVEL_BITS + 1;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_EXEC   = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [CMD_BITS-1:0] cmd_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [CNT_W-1:0]    used_count_ff, used_count_in;

   logic                req_accept;
   logic                emit;

   // cell row signals
   ctl_type             ctl;
   logic                le_v     [TABLE_DEPTH];
   logic                le_ff_v  [TABLE_DEPTH];
   logic                is_floor [TABLE_DEPTH];
   logic [KEY_BITS-1:0] line_v   [TABLE_DEPTH];
   attr_type            attr_v   [TABLE_DEPTH];

   // floor selection
   logic [KEY_BITS-1:0] sel_line;
   logic [ATTR_W-1:0]   sel_attr_bits;
   logic [IDX_W-1:0]    sel_idx;
   logic                found_ff;
   logic [IDX_W-1:0]    fidx_ff;
   logic [KEY_BITS-1:0] fline_ff;
   attr_type            fattr_ff;

   // result forming
   logic [STATUS_BITS-1:0] status_in;
   logic                   hit_in;
   logic [IDX_W-1:0]       idx_in;
   logic [KEY_BITS-1:0]    line_in;
   attr_type               attr_in;
   logic [1:0]             op_in;
   attr_type               op_attr_in;
   logic                   exact;
   logic                   full;

   // response register
   logic                        rsp_valid_ff;
   logic [STATUS_BITS-1:0]      rsp_status_ff;
   logic [INDEX_FIELD_BITS-1:0] rsp_index_ff;
   logic [LINE_FIELD_BITS-1:0]  rsp_line_ff;
   logic [LEVEL_BITS-1:0]       rsp_level_ff;
   logic                        rsp_open_ff;
   logic [TOTAL_FIELD_BITS-1:0] rsp_total_ff;

   // handshake
   assign emit       = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_tready);
   assign req_tready = (state_ff == ST_IDLE) || emit;
   assign req_accept = req_tvalid && req_tready;

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_accept) state_in = ST_SEARCH;
         ST_SEARCH: state_in = ST_EXEC;
         ST_EXEC: begin
            if (emit) begin
               state_in = req_accept ? ST_SEARCH : ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         used_count_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (emit) begin
            used_count_ff <= used_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff <= req_tuser;
         key_ff <= req_tdata[KEY_BITS-1:0];
      end
   end

   // broadcast control to the cells
   assign ctl.search = (state_ff == ST_SEARCH);
   assign ctl.op     = emit ? op_in : OP_NONE;
   assign ctl.attr   = op_attr_in;

   // row of cells
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      logic                prev_le_ff;
      logic                next_le_ff;
      logic                next_le;
      logic [KEY_BITS-1:0] prev_line;
      attr_type            prev_attr;
      logic [KEY_BITS-1:0] next_line;
      attr_type            next_attr;

      if (i == 0) begin : g_first
         assign prev_le_ff = 1'b1;
         assign prev_line  = '0;
         assign prev_attr  = '0;
      end else begin : g_mid_lo
         assign prev_le_ff = le_ff_v[i-1];
         assign prev_line  = line_v[i-1];
         assign prev_attr  = attr_v[i-1];
      end

      if (i == TABLE_DEPTH - 1) begin : g_last
         assign next_le_ff = 1'b0;
         assign next_le    = 1'b0;
         assign next_line  = '0;
         assign next_attr  = '0;
      end else begin : g_mid_hi
         assign next_le_ff = le_ff_v[i+1];
         assign next_le    = le_v[i+1];
         assign next_line  = line_v[i+1];
         assign next_attr  = attr_v[i+1];
      end

      // floor entry is the last one at or below the key
      assign is_floor[i] = le_v[i] && !next_le;

      sft_cell #(
         .KEY_BITS   (KEY_BITS),
         .CNT_BITS   (CNT_W),
         .CELL_INDEX (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .key        (key_ff),
         .used_count (used_count_ff),
         .prev_le_ff (prev_le_ff),
         .next_le_ff (next_le_ff),
         .prev_line  (prev_line),
         .prev_attr  (prev_attr),
         .next_line  (next_line),
         .next_attr  (next_attr),
         .line_ff    (line_v[i]),
         .attr_ff    (attr_v[i]),
         .le         (le_v[i]),
         .le_ff      (le_ff_v[i])
      );
   end

   // one-hot select of the floor entry
   always_comb begin
      sel_line      = '0;
      sel_attr_bits = '0;
      sel_idx       = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (is_floor[i]) begin
            sel_line      = sel_line | line_v[i];
            sel_attr_bits = sel_attr_bits | attr_v[i];
            sel_idx       = sel_idx | IDX_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_SEARCH) begin
         found_ff <= le_v[0];
         fidx_ff  <= sel_idx;
         fline_ff <= sel_line;
         fattr_ff <= attr_type'(sel_attr_bits);
      end
   end

   assign exact = found_ff && (fline_ff == key_ff);
   assign full  = (used_count_ff == CNT_W'(TABLE_DEPTH));

   // command decision
   always_comb begin
      status_in     = STATUS_DONE;
      hit_in        = found_ff;
      idx_in        = fidx_ff;
      line_in       = fline_ff;
      attr_in       = fattr_ff;
      op_in         = OP_NONE;
      op_attr_in    = fattr_ff;
      used_count_in = used_count_ff;
      unique case (cmd_ff)
         CMD_FLOOR: begin
            if (!found_ff) status_in = STATUS_NOMATCH;
         end
         CMD_INSERT: begin
            if (exact) begin
               status_in = STATUS_ALREADY;
            end else if (full) begin
               status_in = STATUS_FULL;
               hit_in    = 1'b0;
            end else begin
               hit_in          = 1'b1;
               idx_in          = found_ff ? IDX_W'(fidx_ff + 1'b1) : '0;
               line_in         = key_ff;
               attr_in.level   = '0;
               attr_in.open    = 1'b1;
               op_in           = OP_INSERT;
               op_attr_in      = attr_in;
               used_count_in   = CNT_W'(used_count_ff + 1'b1);
            end
         end
         CMD_DELETE: begin
            if (!exact) begin
               status_in = STATUS_NOMATCH;
               hit_in    = 1'b0;
            end else begin
               attr_in.open  = 1'b1;
               op_in         = OP_DELETE;
               used_count_in = CNT_W'(used_count_ff - 1'b1);
            end
         end
         CMD_PROMOTE: begin
            if (!exact) begin
               status_in = STATUS_NOMATCH;
               hit_in    = 1'b0;
            end else if (!fattr_ff.open || fattr_ff.level == '0) begin
               status_in = STATUS_REFUSED;
            end else begin
               attr_in.level = LEVEL_BITS'(fattr_ff.level - 1'b1);
               op_in         = OP_MODIFY;
               op_attr_in    = attr_in;
            end
         end
         CMD_DEMOTE: begin
            if (!exact) begin
               status_in = STATUS_NOMATCH;
               hit_in    = 1'b0;
            end else if (!fattr_ff.open || fattr_ff.level >= LEVEL_MAX) begin
               status_in = STATUS_REFUSED;
            end else begin
               attr_in.level = LEVEL_BITS'(fattr_ff.level + 1'b1);
               op_in         = OP_MODIFY;
               op_attr_in    = attr_in;
            end
         end
         CMD_OPEN: begin
            if (!exact) begin
               status_in = STATUS_NOMATCH;
               hit_in    = 1'b0;
            end else if (fattr_ff.open) begin
               status_in = STATUS_ALREADY;
            end else begin
               attr_in.open = 1'b1;
               op_in        = OP_MODIFY;
               op_attr_in   = attr_in;
            end
         end
         CMD_CLOSE: begin
            if (!found_ff) begin
               status_in = STATUS_NOMATCH;
            end else if (!fattr_ff.open) begin
               status_in = STATUS_ALREADY;
            end else begin
               attr_in.open = 1'b0;
               op_in        = OP_MODIFY;
               op_attr_in   = attr_in;
            end
         end
         default: begin
            status_in = STATUS_REFUSED;
            hit_in    = 1'b0;
         end
      endcase
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_status_ff <= status_in;
         rsp_index_ff  <= hit_in ? INDEX_FIELD_BITS'(idx_in) : '0;
         rsp_line_ff   <= hit_in ? LINE_FIELD_BITS'(line_in) : '0;
         rsp_level_ff  <= hit_in ? attr_in.level : '0;
         rsp_open_ff   <= hit_in ? attr_in.open : 1'b0;
         rsp_total_ff  <= TOTAL_FIELD_BITS'(used_count_in);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {7'b0, rsp_total_ff, rsp_open_ff, rsp_level_ff,
                        rsp_line_ff, rsp_index_ff};

endmodule
